// ----- hdl/touch_gesture_classifier_assert.svh -----
// assertion macros for touch_gesture_classifier, which checks its own logic
`ifndef TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH
`define TOUCH_GESTURE_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TGC_ASSERT_NOW(label, clk_s, rst_n_s, lhs, rhs) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (lhs) |-> (rhs)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TGC_ASSERT_NEXT(label, clk_s, rst_n_s, lhs, rhs) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (lhs) |=> (rhs)) \
		else $error("assertion failed");

`endif

// ----- hdl/tgc_pkg.sv -----
package tgc_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_FIRST  = 3'd1,
		MODE_SINGLE = 3'd2,
		MODE_DOUBLE = 3'd3,
		MODE_HOLD   = 3'd4
	} mode_t;

	localparam logic [1:0] GEST_SINGLE = 2'd0;
	localparam logic [1:0] GEST_DOUBLE = 2'd1;
	localparam logic [1:0] GEST_HOLD   = 2'd2;

	localparam int unsigned ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_DOUBLE   = 3'd1,
		REG_TIMEOUT  = 3'd2,
		REG_HOLD     = 3'd3,
		REG_LIMIT    = 3'd4
	} reg_idx_t;

	localparam logic [15:0] DEBOUNCE_RST = 16'd10;
	localparam logic [15:0] DOUBLE_RST   = 16'd200;
	localparam logic [15:0] TIMEOUT_RST  = 16'd700;
	localparam logic [15:0] HOLD_RST     = 16'd800;
	localparam logic [2:0]  LIMIT_RST    = 3'd4;

	typedef struct packed {
		logic [15:0] debounce_ms;
		logic [15:0] double_window_ms;
		logic [15:0] sequence_timeout_ms;
		logic [15:0] hold_ms;
		logic [2:0]  count_limit;
	} cfg_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  gesture;
		logic [2:0]  extra_touches;
	} result_t;

	typedef struct packed {
		mode_t       mode;
		logic [2:0]  following_count;
	} status_t;

endpackage

// ----- hdl/tgc_regs.sv -----
module tgc_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tgc_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output tgc_pkg::cfg_t                    cfg
);

	tgc_pkg::cfg_t    cfg_q;
	tgc_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx   = tgc_pkg::reg_idx_t'(paddr[tgc_pkg::ADDR_W-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms         <= tgc_pkg::DEBOUNCE_RST;
			cfg_q.double_window_ms    <= tgc_pkg::DOUBLE_RST;
			cfg_q.sequence_timeout_ms <= tgc_pkg::TIMEOUT_RST;
			cfg_q.hold_ms             <= tgc_pkg::HOLD_RST;
			cfg_q.count_limit         <= tgc_pkg::LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				tgc_pkg::REG_DEBOUNCE: cfg_q.debounce_ms         <= pwdata[15:0];
				tgc_pkg::REG_DOUBLE:   cfg_q.double_window_ms    <= pwdata[15:0];
				tgc_pkg::REG_TIMEOUT:  cfg_q.sequence_timeout_ms <= pwdata[15:0];
				tgc_pkg::REG_HOLD:     cfg_q.hold_ms             <= pwdata[15:0];
				tgc_pkg::REG_LIMIT:    cfg_q.count_limit         <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tgc_pkg::REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
			tgc_pkg::REG_DOUBLE:   prdata = {16'd0, cfg_q.double_window_ms};
			tgc_pkg::REG_TIMEOUT:  prdata = {16'd0, cfg_q.sequence_timeout_ms};
			tgc_pkg::REG_HOLD:     prdata = {16'd0, cfg_q.hold_ms};
			tgc_pkg::REG_LIMIT:    prdata = {29'd0, cfg_q.count_limit};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

// ----- hdl/tgc_core.sv -----
module tgc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic               level,
	input  tgc_pkg::cfg_t      cfg,
	output tgc_pkg::result_t   res,
	output tgc_pkg::status_t   status
);

	tgc_pkg::mode_t mode_q, mode_d;
	logic        prev_q;
	logic [31:0] tick_q, contact_q, contact_d, last_q, last_d, quiet_q, quiet_d;
	logic [2:0]  count_q, count_d;
	logic        pend_q, pend_d;
	logic [15:0] rwait_q, rwait_d;
	logic        rwaiting_q, rwaiting_d;

	assign status.mode            = mode_q;
	assign status.following_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= tgc_pkg::MODE_IDLE;
			prev_q     <= 1'b0;
			tick_q     <= 32'd0;
			contact_q  <= 32'd0;
			last_q     <= 32'd0;
			quiet_q    <= 32'd0;
			count_q    <= 3'd0;
			pend_q     <= 1'b0;
			rwait_q    <= 16'd0;
			rwaiting_q <= 1'b0;
		end else if (step_en) begin
			mode_q     <= mode_d;
			prev_q     <= level;
			tick_q     <= tick_q + 32'd1;
			contact_q  <= contact_d;
			last_q     <= last_d;
			quiet_q    <= quiet_d;
			count_q    <= count_d;
			pend_q     <= pend_d;
			rwait_q    <= rwait_d;
			rwaiting_q <= rwaiting_d;
		end
	end

	always_comb begin
		logic [31:0] since_last;
		mode_d     = mode_q;
		contact_d  = contact_q;
		last_d     = last_q;
		quiet_d    = quiet_q;
		count_d    = count_q;
		pend_d     = pend_q;
		rwait_d    = rwait_q;
		rwaiting_d = rwaiting_q;
		res        = '0;

		// release filter
		if (rwaiting_q) begin
			if (level) begin
				rwaiting_d = 1'b0;
			end else if (rwait_q != 16'hFFFF) begin
				rwait_d = rwait_q + 16'd1;
			end
		end
		if (prev_q && !level) begin
			rwaiting_d = 1'b1;
			rwait_d    = 16'd0;
		end
		if (rwaiting_d && (rwait_d >= cfg.debounce_ms)) begin
			rwaiting_d = 1'b0;
			if (mode_d == tgc_pkg::MODE_HOLD) begin
				mode_d  = tgc_pkg::MODE_IDLE;
				count_d = 3'd0;
				pend_d  = 1'b0;
			end else begin
				pend_d = 1'b1;
				last_d = tick_q - {16'd0, rwait_d};
			end
		end

		// contact start and hold entry
		if (!prev_q && level) begin
			contact_d = tick_q;
		end
		if (prev_q && level && ((tick_q - contact_d) > {16'd0, cfg.hold_ms})) begin
			if (mode_d != tgc_pkg::MODE_HOLD) begin
				mode_d            = tgc_pkg::MODE_HOLD;
				res.valid         = 1'b1;
				res.gesture       = tgc_pkg::GEST_HOLD;
				res.extra_touches = 3'd0;
			end
		end

		// sequence modes
		since_last = tick_q - last_d;
		case (mode_d)
			tgc_pkg::MODE_IDLE: begin
				if (pend_d) begin
					mode_d  = tgc_pkg::MODE_FIRST;
					quiet_d = tick_q;
					count_d = 3'd0;
					pend_d  = 1'b0;
				end
			end
			tgc_pkg::MODE_FIRST: begin
				if (pend_d && (since_last <= {16'd0, cfg.double_window_ms})) begin
					mode_d  = tgc_pkg::MODE_DOUBLE;
					quiet_d = tick_q;
					pend_d  = 1'b0;
				end else if (since_last > {16'd0, cfg.double_window_ms}) begin
					mode_d  = tgc_pkg::MODE_SINGLE;
					quiet_d = tick_q;
				end
			end
			tgc_pkg::MODE_SINGLE, tgc_pkg::MODE_DOUBLE: begin
				if (pend_d) begin
					if (count_d < cfg.count_limit) begin
						count_d = count_d + 3'd1;
					end
					quiet_d = tick_q;
					pend_d  = 1'b0;
				end else if ((tick_q - quiet_d) > {16'd0, cfg.sequence_timeout_ms}) begin
					res.valid         = 1'b1;
					res.gesture       = (mode_d == tgc_pkg::MODE_DOUBLE) ?
						tgc_pkg::GEST_DOUBLE : tgc_pkg::GEST_SINGLE;
					res.extra_touches = count_d;
					mode_d            = tgc_pkg::MODE_IDLE;
					count_d           = 3'd0;
					pend_d            = 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/touch_gesture_classifier.sv -----
// channel   | handshake                    | payload
// ----------+------------------------------+------------------------------
// sample in | in_valid / in_ready          | touch_level
// gesture   | out_valid / out_ready        | gesture, extra_touches
// config    | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one tick sample per clock unless the output stalls; a sample waits in the input
// register, is classified as it moves on, and its gesture goes to the output register
// the tick update is the only stateful loop: one compare-and-update pass per sample
// arst_n clears the mode, timers and both valid flags; config resets to defaults
// a stalled output holds the input register; a new sample is still taken
// whenever the held one can move forward on the same edge
`include "touch_gesture_classifier_assert.svh"

module touch_gesture_classifier (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       touch_level,
	// gesture channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 gesture,
	output logic [2:0]                 extra_touches,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tgc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	tgc_pkg::cfg_t    cfg;
	tgc_pkg::result_t res;
	tgc_pkg::status_t status;

	logic       valid_s1;
	logic       level_s1;
	logic       advance;
	logic       step_en;
	logic       out_valid_q;
	logic [1:0] gesture_q;
	logic [2:0] extra_q;

	assign pready = 1'b1;

	// the held sample moves on when the output register is free or drains now
	assign advance  = !out_valid_q || out_ready;
	assign step_en  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	tgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			level_s1 <= touch_level;
		end
	end

	// classifier state and per-tick update
	tgc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.level  (level_s1),
		.cfg    (cfg),
		.res    (res),
		.status (status)
	);

	// output register; a tick with no gesture leaves its payload untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && res.valid) begin
			gesture_q <= res.gesture;
			extra_q   <= res.extra_touches;
		end
	end

	assign out_valid     = out_valid_q;
	assign gesture       = gesture_q;
	assign extra_touches = extra_q;

	// an empty input register always takes a transaction
	`TGC_ASSERT_NOW(a_in_ready_when_empty, clk, arst_n, !valid_s1, in_ready)
	// a reported hold leaves the block in hold mode
	`TGC_ASSERT_NEXT(a_hold_enters_mode, clk, arst_n,
		step_en && res.valid && (res.gesture == tgc_pkg::GEST_HOLD),
		status.mode == tgc_pkg::MODE_HOLD)
	// a hold carries no touch count, and no code beyond hold is produced
	`TGC_ASSERT_NOW(a_hold_payload, clk, arst_n, out_valid_q,
		(gesture_q != tgc_pkg::GEST_HOLD || extra_q == 3'd0) && (gesture_q != 2'd3))

endmodule

// ----- tb/tb_touch_gesture_classifier.sv -----
`timescale 1ns / 100ps

// self-checking bench for the touch gesture classifier
// every accepted tick sample runs through a local copy of the classifier;
// any gesture it produces is queued and matched against the gesture channel
module tb_touch_gesture_classifier;

	localparam int CYCLE_LIMIT   = 400000; // far above the slowest correct run
	localparam int DRAIN_LIMIT   = 5000;   // cycles to wait for queued gestures
	localparam int SETTLE_CYCLES = 8;      // input register plus output register, with margin
	localparam int ITEM_TARGET   = 1650;   // tick samples over the whole run

	// gesture that the local classifier says must come out next
	typedef struct {
		logic [1:0] gesture;
		logic [2:0] extra_touches;
	} gesture_rec_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        touch_level;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  gesture;
	logic [2:0]  extra_touches;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [tgc_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// bench bookkeeping
	gesture_rec_t expected_gestures[$];
	int           fault_count;
	int           samples_sent;
	int           cycle_count;
	bit           idle_en;

	// shadow of the register file
	tgc_pkg::cfg_t  shadow_cfg;

	// local classifier state
	tgc_pkg::mode_t cls_mode;
	logic         cls_level;
	logic [31:0]  cls_tick;
	logic [31:0]  cls_contact;
	logic [31:0]  cls_last_touch;
	logic [31:0]  cls_quiet;
	logic [2:0]   cls_count;
	logic         cls_pending;
	logic [15:0]  cls_rel_wait;
	logic         cls_rel_armed;

	touch_gesture_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.touch_level   (touch_level),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gesture       (gesture),
		.extra_touches (extra_touches),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// local classifier
	// ------------------------------------------------------------------

	function automatic void back_to_idle();
		cls_mode    = tgc_pkg::MODE_IDLE;
		cls_count   = 3'd0;
		cls_pending = 1'b0;
	endfunction

	// one millisecond tick; returns 1 when the tick yields a gesture
	function automatic bit classify_tick(input logic level, output logic [1:0] gest,
			output logic [2:0] extra);
		bit          hit;
		logic [31:0] now;
		hit   = 1'b0;
		gest  = tgc_pkg::GEST_SINGLE;
		extra = 3'd0;
		now   = cls_tick;

		// release filter: a high sample drops a pending release (bounce),
		// low samples count up, saturating at the top of the counter
		if (cls_rel_armed) begin
			if (level)
				cls_rel_armed = 1'b0;
			else if (cls_rel_wait != 16'hFFFF)
				cls_rel_wait = cls_rel_wait + 16'd1;
		end
		if (cls_level && !level) begin
			cls_rel_armed = 1'b1;
			cls_rel_wait  = 16'd0;
		end
		// confirmed release; with zero debounce it confirms on the edge itself
		if (cls_rel_armed && cls_rel_wait >= shadow_cfg.debounce_ms) begin
			cls_rel_armed = 1'b0;
			if (cls_mode == tgc_pkg::MODE_HOLD) begin
				back_to_idle();
			end else begin
				cls_pending    = 1'b1;
				cls_last_touch = now - {16'd0, cls_rel_wait};
			end
		end

		// contact start, then hold entry from any mode (open sequence is dropped)
		if (!cls_level && level)
			cls_contact = now;
		if (cls_level && level && (now - cls_contact) > {16'd0, shadow_cfg.hold_ms}) begin
			if (cls_mode != tgc_pkg::MODE_HOLD) begin
				cls_mode = tgc_pkg::MODE_HOLD;
				gest     = tgc_pkg::GEST_HOLD;
				extra    = 3'd0;
				hit      = 1'b1;
			end
		end

		// sequence modes
		case (cls_mode)
			tgc_pkg::MODE_IDLE: begin
				if (cls_pending) begin
					cls_mode    = tgc_pkg::MODE_FIRST;
					cls_quiet   = now;
					cls_count   = 3'd0;
					cls_pending = 1'b0;
				end
			end
			tgc_pkg::MODE_FIRST: begin
				// a late window turns the sequence single and leaves the touch pending
				if (cls_pending &&
						(now - cls_last_touch) <= {16'd0, shadow_cfg.double_window_ms}) begin
					cls_mode    = tgc_pkg::MODE_DOUBLE;
					cls_quiet   = now;
					cls_pending = 1'b0;
				end else if ((now - cls_last_touch) > {16'd0, shadow_cfg.double_window_ms}) begin
					cls_mode  = tgc_pkg::MODE_SINGLE;
					cls_quiet = now;
				end
			end
			tgc_pkg::MODE_SINGLE, tgc_pkg::MODE_DOUBLE: begin
				if (cls_pending) begin
					// count only rises while below the limit; a larger count is kept
					if (cls_count < shadow_cfg.count_limit)
						cls_count = cls_count + 3'd1;
					cls_quiet   = now;
					cls_pending = 1'b0;
				end else if ((now - cls_quiet) > {16'd0, shadow_cfg.sequence_timeout_ms}) begin
					gest  = (cls_mode == tgc_pkg::MODE_DOUBLE) ?
						tgc_pkg::GEST_DOUBLE : tgc_pkg::GEST_SINGLE;
					extra = cls_count;
					hit   = 1'b1;
					back_to_idle();
				end
			end
			default: begin
			end
		endcase

		cls_level = level;
		cls_tick  = now + 32'd1;
		return hit;
	endfunction

	// ------------------------------------------------------------------
	// register port
	// ------------------------------------------------------------------

	// one apb transaction, entered and left at a falling edge
	task automatic apb_access(input logic wr, input tgc_pkg::reg_idx_t idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// the bus stays idle between back to back transactions
		@(negedge clk);
	endtask

	task automatic write_reg(input tgc_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] unused;
		apb_access(1'b1, idx, value, unused);
		case (idx)
			tgc_pkg::REG_DEBOUNCE: shadow_cfg.debounce_ms         = value[15:0];
			tgc_pkg::REG_DOUBLE:   shadow_cfg.double_window_ms    = value[15:0];
			tgc_pkg::REG_TIMEOUT:  shadow_cfg.sequence_timeout_ms = value[15:0];
			tgc_pkg::REG_HOLD:     shadow_cfg.hold_ms             = value[15:0];
			tgc_pkg::REG_LIMIT:    shadow_cfg.count_limit         = value[2:0];
			default: begin
			end
		endcase
	endtask

	task automatic check_reg(input tgc_pkg::reg_idx_t idx);
		logic [31:0] rd;
		logic [31:0] want;
		apb_access(1'b0, idx, 32'd0, rd);
		case (idx)
			tgc_pkg::REG_DEBOUNCE: want = {16'd0, shadow_cfg.debounce_ms};
			tgc_pkg::REG_DOUBLE:   want = {16'd0, shadow_cfg.double_window_ms};
			tgc_pkg::REG_TIMEOUT:  want = {16'd0, shadow_cfg.sequence_timeout_ms};
			tgc_pkg::REG_HOLD:     want = {16'd0, shadow_cfg.hold_ms};
			tgc_pkg::REG_LIMIT:    want = {29'd0, shadow_cfg.count_limit};
			default:               want = 32'd0;
		endcase
		if (rd !== want) begin
			$display("%0t: register %s read expected %h actual %h", $time, idx.name(), want, rd);
			fault_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// sample channel
	// ------------------------------------------------------------------

	// send one tick sample; entered and left at a falling edge, valid stays
	// high into the next transaction unless a gap is inserted
	task automatic send_sample(input logic level);
		logic [1:0] g;
		logic [2:0] c;
		if (idle_en && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid    <= 1'b1;
		touch_level <= level;
		do @(posedge clk); while (!in_ready);
		// transaction accepted at this edge
		if (classify_tick(level, g, c))
			expected_gestures.push_back('{g, c});
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic level, input int n);
		repeat (n) send_sample(level);
	endtask

	// send the n low bits of a pattern, oldest tick in the highest bit
	task automatic send_pattern(input logic [63:0] bits, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_sample(bits[i]);
	endtask

	// wait until every queued gesture has come out, then let the pipeline settle;
	// ticks that yield no gesture may still be in flight when the queue empties
	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_gestures.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_gestures.size() != 0) begin
			$display("%0t: %0d gestures never arrived, next expected %0d/%0d", $time,
				expected_gestures.size(), expected_gestures[0].gesture,
				expected_gestures[0].extra_touches);
			fault_count++;
			expected_gestures.delete();
		end
	endtask

	// registers are only touched with the block quiet
	task automatic apply_settings(input int deb, input int win, input int tmo, input int hld,
			input int lim);
		drain();
		write_reg(tgc_pkg::REG_DEBOUNCE, deb);
		write_reg(tgc_pkg::REG_DOUBLE, win);
		write_reg(tgc_pkg::REG_TIMEOUT, tmo);
		write_reg(tgc_pkg::REG_HOLD, hld);
		write_reg(tgc_pkg::REG_LIMIT, lim);
	endtask

	function automatic int cap(input int v, input int c);
		return (v < c) ? v : c;
	endfunction

	// mostly small timer values, sometimes zero or all ones
	function automatic int pick16(input int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		if (r == 1)
			return 65535;
		return $urandom_range(1, hi);
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset values read back, then a double tap at the reset timings
	task automatic test_default_settings();
		for (int i = 0; i <= tgc_pkg::REG_LIMIT; i++)
			check_reg(tgc_pkg::reg_idx_t'(i));
		// two taps well inside the window, then quiet through the timeout:
		// double with no extra touches
		send_run(1'b1, 1);
		send_run(1'b0, 19);
		send_run(1'b1, 1);
		send_run(1'b0, 720);
	endtask

	// all-ones and zero through every register, with readback
	task automatic test_register_access();
		drain();
		for (int i = 0; i <= tgc_pkg::REG_LIMIT; i++) begin
			write_reg(tgc_pkg::reg_idx_t'(i), 32'hFFFF_FFFF);
			check_reg(tgc_pkg::reg_idx_t'(i));
			write_reg(tgc_pkg::reg_idx_t'(i), 32'd0);
			check_reg(tgc_pkg::reg_idx_t'(i));
		end
	endtask

	task automatic test_directed_cases();
		// bounce on release, double touch, one following touch, timeout
		apply_settings(1, 3, 4, 5, 2);
		send_pattern(17'b10100_100_100_000000, 17);
		// first touch, window runs out and the single times out during the next
		// contact, which turns into a hold; release from hold back to idle
		send_pattern(19'b100_00000_11111111_000, 19);
		// debounce longer than the window: the opening touch is confirmed late, the
		// window has already run out, and a single with no following touch is reported
		apply_settings(4, 2, 3, 5, 3);
		send_pattern(11'b100000_00000, 11);
		// zero debounce confirms on the edge, zero limit keeps the count at zero
		apply_settings(0, 3, 4, 5, 0);
		send_pattern(13'b1010101_000000, 13);
		// count of three, then the limit is lowered below it mid-sequence
		apply_settings(0, 2, 20, 30, 7);
		send_pattern(10'b1010101010, 10);
		apply_settings(0, 2, 20, 30, 1);
		send_pattern(24'b10_0000000000_0000000000_00, 24);
	endtask

	// random phases of mostly well-formed tap bursts and holds, some noise
	task automatic test_random_phases();
		int phase;
		int kind;
		int deb;
		int win;
		int tmo;
		int hld;
		phase = 0;
		while (samples_sent < ITEM_TARGET) begin
			apply_settings(pick16(3), pick16(10), pick16(16), pick16(24), $urandom_range(0, 7));
			deb = shadow_cfg.debounce_ms;
			win = shadow_cfg.double_window_ms;
			tmo = shadow_cfg.sequence_timeout_ms;
			hld = shadow_cfg.hold_ms;
			// one phase in five runs with both sides streaming
			idle_en = (phase % 5 != 2);
			for (int k = 0; k < 12 && samples_sent < ITEM_TARGET; k++) begin
				kind = $urandom_range(0, 9);
				if (kind <= 5) begin
					// burst of taps with gaps around the double window
					repeat ($urandom_range(1, 6)) begin
						send_run(1'b1, $urandom_range(1, cap(hld + 1, 30)));
						send_run(1'b0, $urandom_range(0, cap(deb + win + 2, 30)));
					end
					send_run(1'b0, $urandom_range(0, cap(deb + tmo + 4, 60)));
				end else if (kind <= 7) begin
					// contact around the hold time, then release
					send_run(1'b1, $urandom_range(1, cap(hld + 6, 60)));
					send_run(1'b0, $urandom_range(1, cap(deb + 3, 30)));
				end else begin
					// bouncy noise
					repeat ($urandom_range(4, 20))
						send_sample(1'($urandom_range(0, 1)));
				end
			end
			phase++;
		end
		idle_en = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// gesture checker and receiver stalls
	// ------------------------------------------------------------------

	always @(posedge clk) begin : check_gestures
		gesture_rec_t head;
		if (arst_n && out_valid && out_ready) begin
			if (expected_gestures.size() == 0) begin
				$display("%0t: unexpected gesture, expected none actual %0d/%0d", $time,
					gesture, extra_touches);
				fault_count++;
			end else begin
				head = expected_gestures.pop_front();
				if (gesture !== head.gesture) begin
					$display("%0t: gesture expected %0d actual %0d", $time, head.gesture,
						gesture);
					fault_count++;
				end
				if (extra_touches !== head.extra_touches) begin
					$display("%0t: extra_touches expected %0d actual %0d", $time,
						head.extra_touches, extra_touches);
					fault_count++;
				end
			end
		end
	end

	// receiver stalls at random, with a 15 percent chance, while idling is on
	always @(negedge clk)
		out_ready <= (idle_en && $urandom_range(0, 99) < 15) ? 1'b0 : 1'b1;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL touch_gesture_classifier");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		touch_level = 1'b0;
		out_ready   = 1'b1;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = 32'd0;
		fault_count   = 0;
		samples_sent  = 0;
		cycle_count   = 0;
		idle_en       = 1'b1;

		// register defaults and classifier state after reset
		shadow_cfg.debounce_ms         = tgc_pkg::DEBOUNCE_RST;
		shadow_cfg.double_window_ms    = tgc_pkg::DOUBLE_RST;
		shadow_cfg.sequence_timeout_ms = tgc_pkg::TIMEOUT_RST;
		shadow_cfg.hold_ms             = tgc_pkg::HOLD_RST;
		shadow_cfg.count_limit         = tgc_pkg::LIMIT_RST;
		cls_level      = 1'b0;
		cls_tick       = 32'd0;
		cls_contact    = 32'd0;
		cls_last_touch = 32'd0;
		cls_quiet      = 32'd0;
		cls_rel_wait   = 16'd0;
		cls_rel_armed  = 1'b0;
		back_to_idle();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_settings();
		test_register_access();
		test_directed_cases();
		test_random_phases();
		drain();

		if (fault_count == 0)
			$display("PASS touch_gesture_classifier");
		else
			$display("FAIL touch_gesture_classifier");
		$finish;
	end

endmodule
